// ===== hdl/rhc_pkg.sv =====
// shared types, operation codes and constant helpers for the rgb / hsl converter
package rhc_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam logic [1:0] OP_TO_HSL   = 2'd0;
	localparam logic [1:0] OP_TO_RGB   = 2'd1;
	localparam logic [1:0] OP_BRIGHTEN = 2'd2;
	localparam logic [1:0] OP_DARKEN   = 2'd3;

	localparam logic [6:0] PCT_MAX = 7'd100;
	localparam logic [8:0] HUE_MAX = 9'd359;

	// lightness: floor(10*sum/51) by reciprocal
	localparam int LIT_K = 20;
	localparam int LIT_M = ((1 << LIT_K) + 50) / 51;

	// byte from percent: floor(51*p/20) by reciprocal
	localparam int BYTE_K = 16;
	localparam int BYTE_M = ((1 << BYTE_K) + 19) / 20;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [23:0] color_in;
		logic [8:0]  hue_in;
		logic [6:0]  sat_in;
		logic [6:0]  light_in;
		logic [6:0]  amount;
	} req_t;

	typedef struct packed {
		logic [23:0] color_out;
		logic [8:0]  hue_out;
		logic [6:0]  sat_out;
		logic [6:0]  light_out;
	} rsp_t;

	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] light;
	} hsl_t;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] amt;
		hsl_t       hsl;
	} side_t;

	typedef struct packed {
		logic [1:0] op;
		hsl_t       hsl;
	} pass_t;

	function automatic logic [7:0] pct_to_byte(input logic [6:0] p);
		logic [12:0] x;
		logic [24:0] prod;
		x = 13'(p) * 13'd51;
		prod = 25'(x) * 25'(BYTE_M);
		return prod[BYTE_K+7:BYTE_K];
	endfunction

endpackage

// ===== hdl/rhc_to_hsl.sv =====
// rgb to hsl pipeline: extremes, two restoring dividers over three stages, lightness
module rhc_to_hsl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  rhc_pkg::req_t req,
	output logic          out_valid,
	output rhc_pkg::hsl_t hsl,
	output rhc_pkg::side_t side
);
	import rhc_pkg::*;

	function automatic logic [21:0] div_step(input logic [14:0] rem, input logic [6:0] q,
			input logic [7:0] den, input logic [2:0] sh);
		logic [15:0] trial;
		logic [14:0] rem_n;
		logic [6:0]  q_n;
		trial = {1'b0, rem} - (16'(den) << sh);
		rem_n = rem;
		q_n = q;
		if (!trial[15]) begin
			rem_n = trial[14:0];
			q_n[sh] = 1'b1;
		end
		return {rem_n, q_n};
	endfunction

	logic [7:0] r, g, b, mx, mn, d, sden, hden, mag;
	logic [8:0] sum, base, n;
	logic       grey, neg;
	side_t      side_in;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [14:0] srem_s1, hrem_s1, srem_s2, hrem_s2, srem_s3, hrem_s3;
	logic [6:0]  sq_s2, hq_s2, sq_s3, hq_s3;
	logic [7:0]  sden_s1, hden_s1, sden_s2, hden_s2, sden_s3, hden_s3;
	logic [8:0]  base_s1, base_s2, base_s3;
	logic        neg_s1, neg_s2, neg_s3, grey_s1, grey_s2, grey_s3;
	logic [12:0] lx_s1;
	logic [27:0] lprod_s2;
	logic [6:0]  light_s3;
	side_t       side_s1, side_s2, side_s3, side_s4;
	hsl_t        hsl_s4;

	logic [21:0] sa, sb, sc, ha, hb, hc, sd, se, hd, he, sf, sg, hf, hg;
	logic [8:0]  hue_fin;

	always_comb begin
		r = req.color_in[7:0];
		g = req.color_in[15:8];
		b = req.color_in[23:16];
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		sum = 9'(mx) + 9'(mn);
		d = mx - mn;
		grey = (d == 8'd0);
		if (grey) begin
			sden = 8'd1;
		end else if (sum < 9'd255) begin
			sden = sum[7:0];
		end else begin
			sden = 8'(9'd510 - sum);
		end
		if (b >= r && b >= g) begin
			base = 9'd240;
			n = {1'b0, r} - {1'b0, g};
		end else if (g >= r && g >= b) begin
			base = 9'd120;
			n = {1'b0, b} - {1'b0, r};
		end else if (g >= b) begin
			base = 9'd0;
			n = {1'b0, g} - {1'b0, b};
		end else begin
			base = 9'd360;
			n = {1'b0, g} - {1'b0, b};
		end
		neg = n[8];
		mag = neg ? 8'(9'd0 - n) : n[7:0];
		hden = grey ? 8'd1 : d;
		side_in.op = req.req_type;
		side_in.amt = (req.amount > PCT_MAX) ? PCT_MAX : req.amount;
		side_in.hsl.hue = (req.hue_in > HUE_MAX) ? HUE_MAX : req.hue_in;
		side_in.hsl.sat = (req.sat_in > PCT_MAX) ? PCT_MAX : req.sat_in;
		side_in.hsl.light = (req.light_in > PCT_MAX) ? PCT_MAX : req.light_in;
	end

	// quotient bits 6..4
	always_comb begin
		sa = div_step(srem_s1, 7'd0, sden_s1, 3'd6);
		sb = div_step(sa[21:7], sa[6:0], sden_s1, 3'd5);
		sc = div_step(sb[21:7], sb[6:0], sden_s1, 3'd4);
		ha = div_step(hrem_s1, 7'd0, hden_s1, 3'd6);
		hb = div_step(ha[21:7], ha[6:0], hden_s1, 3'd5);
		hc = div_step(hb[21:7], hb[6:0], hden_s1, 3'd4);
	end

	// quotient bits 3..2
	always_comb begin
		sd = div_step(srem_s2, sq_s2, sden_s2, 3'd3);
		se = div_step(sd[21:7], sd[6:0], sden_s2, 3'd2);
		hd = div_step(hrem_s2, hq_s2, hden_s2, 3'd3);
		he = div_step(hd[21:7], hd[6:0], hden_s2, 3'd2);
	end

	// quotient bits 1..0 and hue assembly
	always_comb begin
		sf = div_step(srem_s3, sq_s3, sden_s3, 3'd1);
		sg = div_step(sf[21:7], sf[6:0], sden_s3, 3'd0);
		hf = div_step(hrem_s3, hq_s3, hden_s3, 3'd1);
		hg = div_step(hf[21:7], hf[6:0], hden_s3, 3'd0);
		if (grey_s3) begin
			hue_fin = 9'd0;
		end else if (neg_s3) begin
			hue_fin = base_s3 - 9'(hg[6:0]) - 9'(hg[21:7] != 15'd0);
		end else begin
			hue_fin = base_s3 + 9'(hg[6:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srem_s1 <= 15'(d) * 15'd100;
			hrem_s1 <= 15'(mag) * 15'd60;
			sden_s1 <= sden;
			hden_s1 <= hden;
			base_s1 <= base;
			neg_s1 <= neg;
			grey_s1 <= grey;
			lx_s1 <= 13'(sum) * 13'd10;
			side_s1 <= side_in;

			srem_s2 <= sc[21:7];
			sq_s2 <= sc[6:0];
			hrem_s2 <= hc[21:7];
			hq_s2 <= hc[6:0];
			sden_s2 <= sden_s1;
			hden_s2 <= hden_s1;
			base_s2 <= base_s1;
			neg_s2 <= neg_s1;
			grey_s2 <= grey_s1;
			lprod_s2 <= 28'(lx_s1) * 28'(LIT_M);
			side_s2 <= side_s1;

			srem_s3 <= se[21:7];
			sq_s3 <= se[6:0];
			hrem_s3 <= he[21:7];
			hq_s3 <= he[6:0];
			sden_s3 <= sden_s2;
			hden_s3 <= hden_s2;
			base_s3 <= base_s2;
			neg_s3 <= neg_s2;
			grey_s3 <= grey_s2;
			light_s3 <= lprod_s2[LIT_K+6:LIT_K];
			side_s3 <= side_s2;

			hsl_s4.hue <= hue_fin;
			hsl_s4.sat <= grey_s3 ? 7'd0 : sg[6:0];
			hsl_s4.light <= light_s3;
			side_s4 <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign hsl = hsl_s4;
	assign side = side_s4;

endmodule

// ===== hdl/rhc_to_rgb.sv =====
// hsl to rgb pipeline in fixed point: scaling, t1/t2, per channel ramps, byte packing
module rhc_to_rgb #(
	parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  rhc_pkg::hsl_t  hsl,
	input  rhc_pkg::pass_t pass,
	output logic           out_valid,
	output rhc_pkg::rsp_t  rsp
);
	import rhc_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int RK = 10;
	localparam int MW = F + 4;
	localparam longint unsigned M100 = (64'd1 << (F + RK)) / 100;
	localparam longint unsigned M360 = (64'd1 << (F + RK)) / 360;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
	localparam logic [F:0] THIRD = (F+1)'((64'd33333 << F) / 64'd100000);
	localparam logic [F:0] TWOTHIRD = (F+1)'((64'd66666 << F) / 64'd100000);

	localparam logic [1:0] RG_RISE = 2'd0;
	localparam logic [1:0] RG_HIGH = 2'd1;
	localparam logic [1:0] RG_FALL = 2'd2;
	localparam logic [1:0] RG_LOW  = 2'd3;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1: reciprocal estimates
	logic [F+10:0] lprod, sprod;
	logic [F+12:0] hprod;
	logic [F:0]    lq_s1, sq_s1, hq_s1;
	logic [6:0]    l_s1, s_s1;
	logic [8:0]    h_s1;
	logic          half_s1, grey_s1;
	pass_t         pass_s1;

	// stage 2: corrected scale values
	logic [F+9:0] lrem, srem, hrem;
	logic [F:0]   lv_s2, sv_s2, hv_s2;
	logic [6:0]   l_s2, l_s3, l_s4, l_s5;
	logic         half_s2, half_s3, grey_s2, grey_s3, grey_s4, grey_s5;
	pass_t        pass_s2, pass_s3, pass_s4, pass_s5, pass_s6;

	// stage 3: l*s and channel hues
	logic [2*F+1:0] lsprod;
	logic [F+1:0]   tr_sum;
	logic [F:0]     tr, tb;
	logic [F:0]     lv_s3, sv_s3, ls_s3;
	logic [F:0]     t3_s3 [3];

	// stage 4: t1, t2 and slope
	logic [F+1:0] t1w, t2w;
	logic [F:0]   t1_s4, t2_s4;
	logic [F+3:0] dif6_s4;
	logic [F:0]   t3_s4 [3];

	// stage 5: ramp products
	logic [1:0]     reg_c [3];
	logic [F:0]     opnd [3];
	logic           neg_c [3];
	logic [2*F+4:0] prod_c [3];
	logic [1:0]     reg_s5 [3];
	logic           neg_s5 [3];
	logic [F+3:0]   m_s5 [3];
	logic [F:0]     t1_s5, t2_s5;

	// stage 6: percent per channel
	logic [F+5:0] vw [3];
	logic [F:0]   vc [3];
	logic [F+7:0] pprod [3];
	logic [6:0]   p_s6 [3];

	rsp_t rsp_s7;
	logic [7:0] byte_c [3];

	always_comb begin
		lprod = (F+11)'(hsl.light) * (F+11)'(M100);
		sprod = (F+11)'(hsl.sat) * (F+11)'(M100);
		hprod = (F+13)'(hsl.hue) * (F+13)'(M360);
	end

	always_comb begin
		lrem = ((F+10)'(l_s1) << F) - (F+10)'(lq_s1) * (F+10)'(100);
		srem = ((F+10)'(s_s1) << F) - (F+10)'(sq_s1) * (F+10)'(100);
		hrem = ((F+10)'(h_s1) << F) - (F+10)'(hq_s1) * (F+10)'(360);
	end

	always_comb begin
		lsprod = (2*F+2)'(lv_s2) * (2*F+2)'(sv_s2);
		tr_sum = (F+2)'(hv_s2) + (F+2)'(THIRD);
		tr = (tr_sum > (F+2)'(ONE)) ? (F+1)'(tr_sum - (F+2)'(ONE)) : tr_sum[F:0];
		tb = (hv_s2 < THIRD) ? (hv_s2 + ONE - THIRD) : (hv_s2 - THIRD);
	end

	always_comb begin
		if (half_s3) begin
			t1w = (F+2)'(lv_s3) + (F+2)'(ls_s3);
		end else begin
			t1w = (F+2)'(lv_s3) + (F+2)'(sv_s3) - (F+2)'(ls_s3);
		end
		t2w = ((F+2)'(lv_s3) << 1) - (F+2)'(t1w[F:0]);
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			neg_c[c] = 1'b0;
			if ((F+4)'(t3_s4[c]) * (F+4)'(6) < (F+4)'(ONE)) begin
				reg_c[c] = RG_RISE;
				opnd[c] = t3_s4[c];
			end else if ((F+4)'(t3_s4[c]) * (F+4)'(2) < (F+4)'(ONE)) begin
				reg_c[c] = RG_HIGH;
				opnd[c] = t3_s4[c];
			end else if ((F+4)'(t3_s4[c]) * (F+4)'(3) < (F+4)'(ONE) * (F+4)'(2)) begin
				reg_c[c] = RG_FALL;
				neg_c[c] = (t3_s4[c] > TWOTHIRD);
				opnd[c] = neg_c[c] ? (t3_s4[c] - TWOTHIRD) : (TWOTHIRD - t3_s4[c]);
			end else begin
				reg_c[c] = RG_LOW;
				opnd[c] = t3_s4[c];
			end
			prod_c[c] = (2*F+5)'(dif6_s4) * (2*F+5)'(opnd[c]);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			case (reg_s5[c])
				RG_RISE: begin
					vw[c] = (F+6)'(t2_s5) + (F+6)'(m_s5[c]);
				end
				RG_HIGH: begin
					vw[c] = (F+6)'(t1_s5);
				end
				RG_FALL: begin
					vw[c] = neg_s5[c] ? ((F+6)'(t2_s5) - (F+6)'(m_s5[c]))
						: ((F+6)'(t2_s5) + (F+6)'(m_s5[c]));
				end
				default: begin
					vw[c] = (F+6)'(t2_s5);
				end
			endcase
			if (vw[c][F+5]) begin
				vc[c] = '0;
			end else if (vw[c] > (F+6)'(ONE)) begin
				vc[c] = ONE;
			end else begin
				vc[c] = vw[c][F:0];
			end
			pprod[c] = (F+8)'(vc[c]) * (F+8)'(100);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			byte_c[c] = pct_to_byte(p_s6[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lq_s1 <= lprod[RK+F:RK];
			sq_s1 <= sprod[RK+F:RK];
			hq_s1 <= hprod[RK+F:RK];
			l_s1 <= hsl.light;
			s_s1 <= hsl.sat;
			h_s1 <= hsl.hue;
			half_s1 <= (hsl.light < 7'd50);
			grey_s1 <= (hsl.sat == 7'd0);
			pass_s1 <= pass;

			lv_s2 <= lq_s1 + (F+1)'(lrem >= (F+10)'(100));
			sv_s2 <= sq_s1 + (F+1)'(srem >= (F+10)'(100));
			hv_s2 <= hq_s1 + (F+1)'(hrem >= (F+10)'(360));
			l_s2 <= l_s1;
			half_s2 <= half_s1;
			grey_s2 <= grey_s1;
			pass_s2 <= pass_s1;

			lv_s3 <= lv_s2;
			sv_s3 <= sv_s2;
			ls_s3 <= lsprod[2*F:F];
			t3_s3[0] <= tr;
			t3_s3[1] <= hv_s2;
			t3_s3[2] <= tb;
			l_s3 <= l_s2;
			half_s3 <= half_s2;
			grey_s3 <= grey_s2;
			pass_s3 <= pass_s2;

			t1_s4 <= t1w[F:0];
			t2_s4 <= t2w[F:0];
			dif6_s4 <= (F+4)'(t1w[F:0] - t2w[F:0]) * (F+4)'(6);
			t3_s4 <= t3_s3;
			l_s4 <= l_s3;
			grey_s4 <= grey_s3;
			pass_s4 <= pass_s3;

			for (int c = 0; c < 3; c++) begin
				reg_s5[c] <= reg_c[c];
				neg_s5[c] <= neg_c[c];
				m_s5[c] <= prod_c[c][2*F+3:F];
			end
			t1_s5 <= t1_s4;
			t2_s5 <= t2_s4;
			l_s5 <= l_s4;
			grey_s5 <= grey_s4;
			pass_s5 <= pass_s4;

			for (int c = 0; c < 3; c++) begin
				p_s6[c] <= grey_s5 ? l_s5 : pprod[c][F+6:F];
			end
			pass_s6 <= pass_s5;

			if (pass_s6.op == OP_TO_HSL) begin
				rsp_s7.color_out <= 24'd0;
				rsp_s7.hue_out <= pass_s6.hsl.hue;
				rsp_s7.sat_out <= pass_s6.hsl.sat;
				rsp_s7.light_out <= pass_s6.hsl.light;
			end else begin
				rsp_s7.color_out <= {byte_c[2], byte_c[1], byte_c[0]};
				rsp_s7.hue_out <= 9'd0;
				rsp_s7.sat_out <= 7'd0;
				rsp_s7.light_out <= 7'd0;
			end
		end
	end

	assign out_valid = v_s7;
	assign rsp = rsp_s7;

endmodule

// ===== hdl/rgb_hsl_color_converter_core.sv =====
// top level of the rgb / hsl colour converter: handshake, lightness adjust, two pipelines
//
// channel   direction  handshake              payload
// request   in         req_valid / req_ready  req (req_t)
// response  out        rsp_valid / rsp_ready  rsp (rsp_t)
//
// a request passes through the rgb to hsl divider stages and then the
// fixed point hsl to rgb stages
// one request accepted every cycle while the response side takes results
// a held response freezes every stage at once; req_ready drops in the same cycle
// reset clears the valid bits only
module rgb_hsl_color_converter_core #(
	parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rhc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rhc_pkg::rsp_t rsp
);
	import rhc_pkg::*;

	logic  en;
	logic  hsl_valid;
	hsl_t  hsl;
	side_t side;
	hsl_t  cvt;
	pass_t pass;
	logic [7:0] lsum;

	assign en = !rsp_valid || rsp_ready;
	assign req_ready = en;

	rhc_to_hsl u_to_hsl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.req       (req),
		.out_valid (hsl_valid),
		.hsl       (hsl),
		.side      (side)
	);

	// picks the hsl fed to the rgb pipeline; lightness adjust for brighten and darken
	always_comb begin
		cvt = hsl;
		lsum = 8'(hsl.light) + 8'(side.amt);
		case (side.op)
			OP_TO_HSL: begin
				cvt = hsl;
			end
			OP_TO_RGB: begin
				cvt = side.hsl;
			end
			OP_BRIGHTEN: begin
				cvt.light = (lsum > 8'(PCT_MAX)) ? PCT_MAX : lsum[6:0];
			end
			OP_DARKEN: begin
				cvt.light = (side.amt >= hsl.light) ? 7'd0 : (hsl.light - side.amt);
			end
			default: begin
				cvt = hsl;
			end
		endcase
		pass.op = side.op;
		pass.hsl = hsl;
	end

	rhc_to_rgb #(
		.FRAC_BITS (FRAC_BITS)
	) u_to_rgb (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (hsl_valid),
		.hsl       (cvt),
		.pass      (pass),
		.out_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the rgb / hsl colour converter with a small scoreboard class
module tb_top;
	import rhc_pkg::*;

	localparam int FB = 16;
	localparam longint ONE = 64'sd1 << FB;
	localparam longint THIRD = (64'sd33333 << FB) / 100000;
	localparam longint TWOTHIRD = (64'sd66666 << FB) / 100000;
	localparam int N_RAND = 1200;
	localparam int LIMIT = 400000;

	class colour_scoreboard;
		rsp_t pending[$];
		int errors = 0;

		function automatic longint fxm(longint a, longint b);
			longint ua, ub, m;
			ua = (a < 0) ? -a : a;
			ub = (b < 0) ? -b : b;
			m = (ua * ub) >>> FB;
			return ((a < 0) != (b < 0)) ? -m : m;
		endfunction

		function automatic int hue_part(int base, int num, int d);
			if (num >= 0)
				return base + (60 * num) / d;
			return base - (60 * (-num) + d - 1) / d;
		endfunction

		function automatic void hsl_of(logic [23:0] c, output int h, output int s,
				output int l);
			int r, g, b, mx, mn, d, sum;
			r = int'(c[7:0]);
			g = int'(c[15:8]);
			b = int'(c[23:16]);
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			sum = mx + mn;
			d = mx - mn;
			l = (100 * sum) / 510;
			h = 0;
			s = 0;
			if (d == 0)
				return;
			s = (sum < 255) ? (100 * d) / sum : (100 * d) / (510 - sum);
			if (b >= r && b >= g) h = hue_part(240, r - g, d);
			else if (g >= r && g >= b) h = hue_part(120, b - r, d);
			else if (g >= b) h = hue_part(0, g - b, d);
			else h = hue_part(360, g - b, d);
		endfunction

		function automatic int chan_pct(longint t1, longint t2, longint t3);
			longint v;
			if (6 * t3 < ONE) v = t2 + fxm((t1 - t2) * 6, t3);
			else if (2 * t3 < ONE) v = t1;
			else if (3 * t3 < 2 * ONE) v = t2 + fxm((t1 - t2) * 6, TWOTHIRD - t3);
			else v = t2;
			if (v < 0) v = 0;
			if (v > ONE) v = ONE;
			return int'((v * 100) >>> FB);
		endfunction

		function automatic logic [23:0] rgb_of(int h, int s, int l);
			int pr, pg, pb;
			longint lf, sf, hf, t1, t2, t3;
			if (s == 0) begin
				pr = l;
				pg = l;
				pb = l;
			end else begin
				lf = (longint'(l) << FB) / 100;
				sf = (longint'(s) << FB) / 100;
				hf = (longint'(h) << FB) / 360;
				t1 = (l < 50) ? lf + fxm(lf, sf) : lf + sf - fxm(lf, sf);
				t2 = 2 * lf - t1;
				t3 = hf + THIRD;
				if (t3 > ONE) t3 -= ONE;
				pr = chan_pct(t1, t2, t3);
				pg = chan_pct(t1, t2, hf);
				t3 = hf - THIRD;
				if (t3 < 0) t3 += ONE;
				pb = chan_pct(t1, t2, t3);
			end
			pr = pr * 255 / 100;
			pg = pg * 255 / 100;
			pb = pb * 255 / 100;
			return {pb[7:0], pg[7:0], pr[7:0]};
		endfunction

		function automatic void note_request(req_t q);
			rsp_t e;
			int h, s, l, hu, sa, li, am;
			hu = int'((q.hue_in > HUE_MAX) ? HUE_MAX : q.hue_in);
			sa = int'((q.sat_in > PCT_MAX) ? PCT_MAX : q.sat_in);
			li = int'((q.light_in > PCT_MAX) ? PCT_MAX : q.light_in);
			am = int'((q.amount > PCT_MAX) ? PCT_MAX : q.amount);
			e = '0;
			case (q.req_type)
				OP_TO_HSL: begin
					hsl_of(q.color_in, h, s, l);
					e.hue_out = 9'(h);
					e.sat_out = 7'(s);
					e.light_out = 7'(l);
				end
				OP_TO_RGB: e.color_out = rgb_of(hu, sa, li);
				default: begin
					hsl_of(q.color_in, h, s, l);
					if (q.req_type == OP_BRIGHTEN) l = (l + am > 100) ? 100 : l + am;
					else l = (am >= l) ? 0 : l - am;
					e.color_out = rgb_of(h, s, l);
				end
			endcase
			pending.push_back(e);
		endfunction

		function automatic void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response %h", a);
				return;
			end
			e = pending.pop_front();
			if (a.color_out !== e.color_out || a.hue_out !== e.hue_out ||
					a.sat_out !== e.sat_out || a.light_out !== e.light_out) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp c=%h h=%0d s=%0d l=%0d got c=%h h=%0d s=%0d l=%0d",
						e.color_out, e.hue_out, e.sat_out, e.light_out,
						a.color_out, a.hue_out, a.sat_out, a.light_out);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int cycles = 0;
	bit src_done = 0;
	colour_scoreboard sb = new();

	rgb_hsl_color_converter_core DUT (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && req_valid && req_ready) sb.note_request(req);
		if (arst_n && rsp_valid && rsp_ready) sb.check_response(rsp);
	end

	// receiver stalls
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			g = (cycles % 3000 < 800) ? 0 : gap_len();
			if (g > 0) begin
				@(negedge clk);
				rsp_ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
		end
	end

	task automatic send(input req_t q);
		int g;
		g = (cycles % 2500 < 600) ? 0 : gap_len();
		@(negedge clk);
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req <= q;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic send_fields(input logic [1:0] op, input logic [23:0] c,
			input logic [8:0] h, input logic [6:0] s, input logic [6:0] l,
			input logic [6:0] a);
		req_t q;
		q.req_type = op;
		q.color_in = c;
		q.hue_in = h;
		q.sat_in = s;
		q.light_in = l;
		q.amount = a;
		send(q);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		req_t q;
		int p;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_fields(OP_TO_HSL, 24'h000000, 0, 0, 0, 0);
		send_fields(OP_TO_HSL, 24'hffffff, 0, 0, 0, 0);
		send_fields(OP_TO_HSL, 24'h0000ff, 0, 0, 0, 0);
		send_fields(OP_TO_HSL, 24'h00ff00, 0, 0, 0, 0);
		send_fields(OP_TO_HSL, 24'hff0000, 0, 0, 0, 0);
		send_fields(OP_TO_HSL, 24'hff00ff, 0, 0, 0, 0);
		send_fields(OP_TO_HSL, 24'h8000ff, 0, 0, 0, 0);
		send_fields(OP_TO_RGB, 24'h0, 0, 0, 50, 0);
		send_fields(OP_TO_RGB, 24'h0, 511, 127, 127, 0);
		send_fields(OP_TO_RGB, 24'h0, 359, 100, 50, 0);
		send_fields(OP_TO_RGB, 24'h0, 120, 100, 49, 0);
		send_fields(OP_TO_RGB, 24'h0, 240, 50, 75, 0);
		send_fields(OP_TO_RGB, 24'h0, 239, 100, 50, 0);
		send_fields(OP_TO_RGB, 24'h0, 360, 1, 1, 0);
		send_fields(OP_BRIGHTEN, 24'h336699, 0, 0, 0, 127);
		send_fields(OP_BRIGHTEN, 24'h336699, 0, 0, 0, 0);
		send_fields(OP_BRIGHTEN, 24'h808080, 0, 0, 0, 20);
		send_fields(OP_DARKEN, 24'h336699, 0, 0, 0, 127);
		send_fields(OP_DARKEN, 24'hc0ffee, 0, 0, 0, 10);
		send_fields(OP_DARKEN, 24'hffffff, 0, 0, 0, 100);
		drain();
		for (int i = 0; i < N_RAND; i++) begin
			q = req_t'(56'({$urandom, $urandom}));
			p = $urandom_range(0, 9);
			if (p < 8) begin
				q.hue_in = 9'($urandom_range(0, 359));
				q.sat_in = 7'($urandom_range(0, 100));
				q.light_in = 7'($urandom_range(0, 100));
				q.amount = 7'($urandom_range(0, 100));
			end
			if (p == 0) q.sat_in = 7'd0;
			send(q);
			if (i == N_RAND / 2) drain();
		end
		@(negedge clk);
		req_valid <= 1'b0;
		src_done = 1;
	end

	initial begin
		wait (src_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	final begin
		if (sb.pending.size() != 0 && sb.errors == 0) sb.errors++;
	end
endmodule
